FILE: src/imud_pkg.sv
// Shared types and constants for the IMU FIFO packet decoder.
// Used by every module under src; depends on nothing else.
package imud_pkg;

	// Default packet length in bytes, and the bytes that carry decoded content.
	localparam int PKT_BYTES_DEF = 20;
	localparam int MOTION_BYTES  = 20;

	// Header codes.
	localparam logic [7:0] HDR_MOTION   = 8'h78;
	localparam logic [7:0] HDR_EXTERNAL = 8'h70;

	// Empty-sensor word, seen as a high byte and a low byte.
	localparam logic [7:0] EMPTY_HI = 8'h80;
	localparam logic [7:0] EMPTY_LO = 8'h00;

	// Byte offsets inside a motion packet.
	localparam int OFS_ACCEL = 1;
	localparam int OFS_GYRO  = 7;
	localparam int OFS_NIB   = 17;

	localparam int AXIS_W = 20;

	typedef enum logic [1:0] {
		KIND_INVALID  = 2'd0,
		KIND_EXTERNAL = 2'd1,
		KIND_MOTION   = 2'd2
	} entry_kind_t;

	// Stored bytes of one packet, byte 0 in the lowest slot.
	typedef logic [MOTION_BYTES-1:0][7:0] pkt_bytes_t;

	// One decoded result.
	typedef struct packed {
		entry_kind_t               kind;
		logic                      accel_ok;
		logic                      gyro_ok;
		logic signed [AXIS_W-1:0]  accel_x;
		logic signed [AXIS_W-1:0]  accel_y;
		logic signed [AXIS_W-1:0]  accel_z;
		logic signed [AXIS_W-1:0]  gyro_x;
		logic signed [AXIS_W-1:0]  gyro_y;
		logic signed [AXIS_W-1:0]  gyro_z;
	} decode_res_t;

endpackage

FILE: src/imud_capture.sv
// Byte position counter and packet byte store for the IMU FIFO decoder.
// Depends on imud_pkg.
module imud_capture import imud_pkg::*; #(
	parameter int PACKET_BYTES = PKT_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_take,
	input  logic [7:0] packet_byte,
	output logic       last_byte,
	output pkt_bytes_t pkt_bytes
);

	localparam int POS_W = $clog2(PACKET_BYTES);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_eff;
	logic [7:0]       store_q [MOTION_BYTES];

	// An out-of-range position counts as the last byte of the packet.
	assign pos_eff   = (pos_q >= POS_LAST) ? POS_LAST : pos_q;
	assign last_byte = (pos_eff == POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (byte_take) begin
			pos_q <= last_byte ? '0 : pos_eff + 1'b1;
		end
	end

	// Each slot takes the beat whose position matches it; later bytes are dropped.
	always_ff @(posedge clk) begin
		for (int i = 0; i < MOTION_BYTES; i++) begin
			if (byte_take && (32'(pos_eff) == i)) begin
				store_q[i] <= packet_byte;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MOTION_BYTES; i++) begin
			pkt_bytes[i] = store_q[i];
		end
	end

endmodule

FILE: src/imud_decode.sv
// Combinational decode of one stored packet into a result.
// Depends on imud_pkg.
module imud_decode import imud_pkg::*; (
	input  pkt_bytes_t  pkt_bytes,
	output decode_res_t res
);

	logic                     accel_ok;
	logic                     gyro_ok;
	logic [2:0][AXIS_W-1:0]   accel_axis;
	logic [2:0][AXIS_W-1:0]   gyro_axis;
	logic                     accel_empty;
	logic                     gyro_empty;

	// A sensor is empty when all three words read 0x8000.
	always_comb begin
		accel_empty = 1'b1;
		gyro_empty  = 1'b1;
		for (int i = 0; i < 3; i++) begin
			accel_empty = accel_empty && (pkt_bytes[OFS_ACCEL + 2*i] == EMPTY_HI)
				&& (pkt_bytes[OFS_ACCEL + 2*i + 1] == EMPTY_LO);
			gyro_empty = gyro_empty && (pkt_bytes[OFS_GYRO + 2*i] == EMPTY_HI)
				&& (pkt_bytes[OFS_GYRO + 2*i + 1] == EMPTY_LO);
		end
		accel_ok = !accel_empty;
		gyro_ok  = !gyro_empty;
	end

	// Each axis is high byte, low byte and its extension nibble.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			accel_axis[i] = {pkt_bytes[OFS_ACCEL + 2*i], pkt_bytes[OFS_ACCEL + 2*i + 1],
				pkt_bytes[OFS_NIB + i][7:4]};
			gyro_axis[i] = {pkt_bytes[OFS_GYRO + 2*i], pkt_bytes[OFS_GYRO + 2*i + 1],
				pkt_bytes[OFS_NIB + i][3:0]};
		end
	end

	// Pick the result by header and sensor validity; unused fields stay zero.
	always_comb begin
		res = '0;
		if (pkt_bytes[0] == HDR_EXTERNAL) begin
			res.kind = KIND_EXTERNAL;
		end else if ((pkt_bytes[0] == HDR_MOTION) && (accel_ok || gyro_ok)) begin
			res.kind     = KIND_MOTION;
			res.accel_ok = accel_ok;
			res.gyro_ok  = gyro_ok;
			if (accel_ok) begin
				res.accel_x = accel_axis[0];
				res.accel_y = accel_axis[1];
				res.accel_z = accel_axis[2];
			end
			if (gyro_ok) begin
				res.gyro_x = gyro_axis[0];
				res.gyro_y = gyro_axis[1];
				res.gyro_z = gyro_axis[2];
			end
		end
	end

endmodule

FILE: src/imu_fifo_packet_decoder.sv
// IMU FIFO packet decoder: one byte beat a cycle in, one result per packet out.
// An accepted last byte sets the pending flag; the result register then loads the
// decoded packet once free. Throughput: one byte per cycle sustained; input
// stalls only while a decoded packet waits for a full output register not drained.
// Reset (arst_n, asynchronous, active low) clears the byte position and valids.
// Depends on imud_pkg, imud_capture and imud_decode.
module imu_fifo_packet_decoder import imud_pkg::*; #(
	parameter int PACKET_BYTES = PKT_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         packet_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         entry_kind,
	output logic               accel_ok,
	output logic               gyro_ok,
	output logic signed [19:0] accel_x,
	output logic signed [19:0] accel_y,
	output logic signed [19:0] accel_z,
	output logic signed [19:0] gyro_x,
	output logic signed [19:0] gyro_y,
	output logic signed [19:0] gyro_z
);

	logic        byte_take;
	logic        last_byte;
	logic        pend_s1;
	logic        advance;
	logic        out_valid_q;
	pkt_bytes_t  pkt_bytes;
	decode_res_t dec_res;
	decode_res_t res_q;

	// A complete packet moves to the result register once that register frees up.
	assign advance   = pend_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !pend_s1 || advance;
	assign byte_take = in_valid && in_ready;

	imud_capture #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_take  (byte_take),
		.packet_byte(packet_byte),
		.last_byte  (last_byte),
		.pkt_bytes  (pkt_bytes)
	);

	imud_decode u_decode (
		.pkt_bytes(pkt_bytes),
		.res      (dec_res)
	);

	// Pending flag: set when a packet's last byte lands in the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (byte_take && last_byte) begin
			pend_s1 <= 1'b1;
		end else if (advance) begin
			pend_s1 <= 1'b0;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= dec_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign entry_kind = 2'(res_q.kind);
	assign accel_ok   = res_q.accel_ok;
	assign gyro_ok    = res_q.gyro_ok;
	assign accel_x    = res_q.accel_x;
	assign accel_y    = res_q.accel_y;
	assign accel_z    = res_q.accel_z;
	assign gyro_x     = res_q.gyro_x;
	assign gyro_y     = res_q.gyro_y;
	assign gyro_z     = res_q.gyro_z;

endmodule
